/* rtl/lac_pkg.sv */
// ----------------------------------------------------------------------------
// lac_pkg
// Shared types and constants for the layer alpha converter.
// ----------------------------------------------------------------------------
`default_nettype none

package lac_pkg;

    localparam int ALPHA_LAYERS = 3;
    localparam int PIXEL_FIELDS = 3;
    localparam int ALPHA_W      = 8;
    localparam int LC_W         = 3;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 3;
    localparam int DIV_STEPS    = 4;
    localparam int NSTAGE       = DIV_STEPS + 2;

    localparam logic [ALPHA_W-1:0] FULL_ALPHA = 8'hFF;

    typedef logic [ALPHA_W-1:0]                    alpha_t;
    typedef logic [PIXEL_FIELDS-1:0][ALPHA_W-1:0]  alpha_vec_t;
    typedef logic [NSTAGE-1:0]                     stage_en_t;

    typedef enum logic {
        DIR_TO_SHARE   = 1'b0,
        DIR_TO_STACKED = 1'b1
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAYER_COUNT = 1'b0,
        REG_DIRECTION   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic       bypass;
        dir_t       dir;
        alpha_vec_t alpha;
    } meta_t;

endpackage

`default_nettype wire

/* rtl/lac_pipe.sv */
// ----------------------------------------------------------------------------
// lac_pipe
// Stage valid bits, per-stage advance enables and per-item control.
// ----------------------------------------------------------------------------
`default_nettype none

module lac_pipe (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire lac_pkg::meta_t     meta_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output lac_pkg::meta_t          meta_out,
    output lac_pkg::stage_en_t      en
);
    import lac_pkg::*;

    logic [NSTAGE-1:0] valid_reg;
    meta_t             meta_reg [NSTAGE];

    assign en[NSTAGE-1] = ~valid_reg[NSTAGE-1] | out_ready;

    for (genvar i = 0; i < NSTAGE - 1; i++) begin : g_en
        assign en[i] = ~valid_reg[i] | en[i+1];
    end

    for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
        if (i == 0) begin : g_first
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i] <= 1'b0;
                end
                else if (en[i])
                begin
                    valid_reg[i] <= in_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[i])
                begin
                    meta_reg[i] <= meta_in;
                end
            end
        end
        else begin : g_rest
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i] <= 1'b0;
                end
                else if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[i])
                begin
                    meta_reg[i] <= meta_reg[i-1];
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NSTAGE-1];
    assign meta_out  = meta_reg[NSTAGE-1];

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !out_ready |-> !in_ready)
        else $error("input taken while every stage is full and stalled");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted item did not land in first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NSTAGE-1] && !out_ready |=> valid_reg[NSTAGE-1])
        else $error("stalled result dropped");

endmodule

`default_nettype wire

/* rtl/lac_fwd.sv */
// ----------------------------------------------------------------------------
// lac_fwd
// Stacked-to-share chain: multiply by visibility, round by 255, subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module lac_fwd (
    input  wire logic                clk,
    input  wire lac_pkg::stage_en_t  en,
    input  wire lac_pkg::alpha_vec_t src,
    output lac_pkg::alpha_vec_t      res
);
    import lac_pkg::*;

    function automatic alpha_t div255_cap(input logic [15:0] p, input alpha_t vis);
        logic [16:0] x;
        logic [24:0] y;
        logic [8:0]  q;
        x = {1'b0, p} + 17'd128;
        y = {x, 8'b0} + {8'b0, x};
        q = y[24:16];
        return (q > {1'b0, vis}) ? vis : q[7:0];
    endfunction

    logic [15:0] p2_reg, p1_reg, p0_reg;
    alpha_t      s1_reg [2];
    alpha_t      s0_reg [4];
    alpha_t      vis_reg [2:5];
    alpha_t      v2_reg [2:6];
    alpha_t      v1_reg [4:6];
    alpha_t      v0_reg;
    alpha_t      v2_next, v1_next;

    assign v2_next = div255_cap(p2_reg, FULL_ALPHA);
    assign v1_next = div255_cap(p1_reg, vis_reg[3]);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p2_reg    <= {8'b0, src[2]} * {8'b0, FULL_ALPHA};
            s1_reg[0] <= src[1];
            s0_reg[0] <= src[0];
        end
        if (en[1])
        begin
            v2_reg[2]  <= v2_next;
            vis_reg[2] <= FULL_ALPHA - v2_next;
            s1_reg[1]  <= s1_reg[0];
            s0_reg[1]  <= s0_reg[0];
        end
        if (en[2])
        begin
            p1_reg     <= {8'b0, s1_reg[1]} * {8'b0, vis_reg[2]};
            v2_reg[3]  <= v2_reg[2];
            vis_reg[3] <= vis_reg[2];
            s0_reg[2]  <= s0_reg[1];
        end
        if (en[3])
        begin
            v2_reg[4]  <= v2_reg[3];
            v1_reg[4]  <= v1_next;
            vis_reg[4] <= vis_reg[3] - v1_next;
            s0_reg[3]  <= s0_reg[2];
        end
        if (en[4])
        begin
            p0_reg     <= {8'b0, s0_reg[3]} * {8'b0, vis_reg[4]};
            v2_reg[5]  <= v2_reg[4];
            v1_reg[5]  <= v1_reg[4];
            vis_reg[5] <= vis_reg[4];
        end
        if (en[5])
        begin
            v2_reg[6] <= v2_reg[5];
            v1_reg[6] <= v1_reg[5];
            v0_reg    <= div255_cap(p0_reg, vis_reg[5]);
        end
    end

    assign res[2] = v2_reg[6];
    assign res[1] = v1_reg[6];
    assign res[0] = v0_reg;

endmodule

`default_nettype wire

/* rtl/lac_rev.sv */
// ----------------------------------------------------------------------------
// lac_rev
// Share-to-stacked lanes: pipelined restoring divide by remaining visibility.
// ----------------------------------------------------------------------------
`default_nettype none

module lac_rev (
    input  wire logic                clk,
    input  wire lac_pkg::stage_en_t  en,
    input  wire lac_pkg::alpha_vec_t src,
    output lac_pkg::alpha_vec_t      res,
    output logic                     sat
);
    import lac_pkg::*;

    localparam int BITS_PER_STEP = ALPHA_W / DIV_STEPS;
    localparam int NUM_W         = 2 * ALPHA_W;

    typedef struct packed {
        logic              act;
        logic              ovf;
        alpha_t            den;
        logic [NUM_W-1:0]  rem;
        alpha_t            quo;
    } div_t;

    function automatic div_t div_bits(input div_t d, input int hi);
        div_t             r;
        logic [NUM_W-1:0] sub;
        int               pos;
        r = d;
        for (int b = 0; b < BITS_PER_STEP; b++)
        begin
            pos = hi - b;
            sub = {{ALPHA_W{1'b0}}, r.den} << pos;
            if (r.rem >= sub)
            begin
                r.rem      = r.rem - sub;
                r.quo[pos] = 1'b1;
            end
        end
        return r;
    endfunction

    div_t                    div_reg [DIV_STEPS+1][PIXEL_FIELDS];
    logic [PIXEL_FIELDS-1:0] act_c;
    alpha_t                  den_c [PIXEL_FIELDS];
    alpha_vec_t              res_reg;
    logic [PIXEL_FIELDS-1:0] sat_reg;

    always_comb
    begin
        alpha_t vis;
        logic   live;
        vis  = FULL_ALPHA;
        live = 1'b1;
        for (int k = PIXEL_FIELDS - 1; k >= 0; k--)
        begin
            act_c[k] = live;
            den_c[k] = vis;
            if (live)
            begin
                if (src[k] >= vis)
                begin
                    live = 1'b0;
                end
                else
                begin
                    vis = vis - src[k];
                end
            end
        end
    end

    for (genvar k = 0; k < PIXEL_FIELDS; k++) begin : g_layer
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] rnd_lim;
        logic [ALPHA_W:0] sum;
        div_t             last;

        assign num = {src[k], {ALPHA_W{1'b0}}} - {{ALPHA_W{1'b0}}, src[k]};

        always_ff @(posedge clk)
        begin
            if (en[0])
            begin
                div_reg[0][k].act <= act_c[k];
                div_reg[0][k].ovf <= num >= {den_c[k], {ALPHA_W{1'b0}}};
                div_reg[0][k].den <= den_c[k];
                div_reg[0][k].rem <= num;
                div_reg[0][k].quo <= '0;
            end
        end

        for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    div_reg[j][k] <= div_bits(div_reg[j-1][k],
                                              ALPHA_W - 1 - (j - 1) * BITS_PER_STEP);
                end
            end
        end

        assign last    = div_reg[DIV_STEPS][k];
        assign rnd_lim = {{ALPHA_W{1'b0}}, last.den >> 1};
        assign sum     = {1'b0, last.quo} + {{ALPHA_W{1'b0}}, last.rem > rnd_lim};

        always_ff @(posedge clk)
        begin
            if (en[DIV_STEPS+1])
            begin
                if (!last.act)
                begin
                    res_reg[k] <= '0;
                    sat_reg[k] <= 1'b0;
                end
                else if (last.ovf || sum[ALPHA_W])
                begin
                    res_reg[k] <= FULL_ALPHA;
                    sat_reg[k] <= 1'b1;
                end
                else
                begin
                    res_reg[k] <= sum[ALPHA_W-1:0];
                    sat_reg[k] <= 1'b0;
                end
            end
        end
    end

    assign res = res_reg;
    assign sat = |sat_reg;

endmodule

`default_nettype wire

/* rtl/layer_alpha_convert.sv */
// ----------------------------------------------------------------------------
// layer_alpha_convert
// Converts the three layer alphas of a pixel between stacked and share form.
// ----------------------------------------------------------------------------
// Six-stage pipeline: one item per clock while not every stage is full and stalled.
// An item enters stage 0 at the edge that accepts it and its result is offered
// from stage 5. Depth is set by the stacked-to-share chain, three dependent
// multiply and round-by-255 steps of two stages each; the share-to-stacked
// divider runs beside it with two quotient bits per stage. Stages advance on
// their own, so in_ready follows out_ready and the occupancy of the stages.
// Write layer_count and direction only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module layer_alpha_convert (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [lac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lac_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [lac_pkg::ALPHA_W-1:0]        alpha_0,
    input  wire logic [lac_pkg::ALPHA_W-1:0]        alpha_1,
    input  wire logic [lac_pkg::ALPHA_W-1:0]        alpha_2,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [lac_pkg::ALPHA_W-1:0]             out_0,
    output logic [lac_pkg::ALPHA_W-1:0]             out_1,
    output logic [lac_pkg::ALPHA_W-1:0]             out_2,
    output logic                                    saturated
);
    import lac_pkg::*;

    logic [LC_W-1:0] layer_count_reg;
    dir_t            direction_reg;
    alpha_vec_t      raw;
    alpha_vec_t      src;
    alpha_vec_t      fwd_res;
    alpha_vec_t      rev_res;
    alpha_vec_t      final_res;
    logic            rev_sat;
    meta_t           meta_in;
    meta_t           meta_out;
    stage_en_t       en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_count_reg <= LC_W'(1);
            direction_reg   <= DIR_TO_SHARE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LAYER_COUNT: layer_count_reg <= cfg_data[LC_W-1:0];
                REG_DIRECTION:   direction_reg   <= dir_t'(cfg_data[0]);
            endcase
        end
    end

    assign raw[0] = alpha_0;
    assign raw[1] = alpha_1;
    assign raw[2] = alpha_2;

    // drop layers above the top used one
    always_comb
    begin
        for (int k = 0; k < PIXEL_FIELDS; k++)
        begin
            if (k < ALPHA_LAYERS && LC_W'(k + 1) < layer_count_reg)
            begin
                src[k] = raw[k];
            end
            else
            begin
                src[k] = '0;
            end
        end
    end

    assign meta_in.bypass = layer_count_reg < LC_W'(2);
    assign meta_in.dir    = direction_reg;
    assign meta_in.alpha  = raw;

    lac_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .meta_in   (meta_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .meta_out  (meta_out),
        .en        (en)
    );

    lac_fwd u_fwd (
        .clk (clk),
        .en  (en),
        .src (src),
        .res (fwd_res)
    );

    lac_rev u_rev (
        .clk (clk),
        .en  (en),
        .src (src),
        .res (rev_res),
        .sat (rev_sat)
    );

    always_comb
    begin
        if (meta_out.bypass)
        begin
            final_res = meta_out.alpha;
            saturated = 1'b0;
        end
        else if (meta_out.dir == DIR_TO_STACKED)
        begin
            final_res = rev_res;
            saturated = rev_sat;
        end
        else
        begin
            final_res = fwd_res;
            saturated = 1'b0;
        end
    end

    assign out_0 = final_res[0];
    assign out_1 = final_res[1];
    assign out_2 = final_res[2];

    a_sat_reverse_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> !meta_out.bypass && meta_out.dir == DIR_TO_STACKED)
        else $error("saturation flagged outside share-to-stacked conversion");

    a_share_budget: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !meta_out.bypass && meta_out.dir == DIR_TO_SHARE |->
        ({2'b0, fwd_res[0]} + {2'b0, fwd_res[1]} + {2'b0, fwd_res[2]}) <= 10'd255)
        else $error("shares exceed full visibility");

endmodule

`default_nettype wire

/* tb/layer_alpha_convert_tb.sv */
// ----------------------------------------------------------------------------
// layer_alpha_convert_tb
// Drives terrain pixels through the layer alpha converter under every layer
// count and both directions. A scoreboard predicts each converted pixel as the
// item is accepted and checks results in order, with random gaps and stalls.
// ----------------------------------------------------------------------------
module layer_alpha_convert_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lac_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        alpha_t o0;
        alpha_t o1;
        alpha_t o2;
        logic   sat;
    } pixel_res_t;

    class alpha_scoreboard;
        logic [LC_W-1:0] layer_cnt;
        dir_t            dir;
        pixel_res_t      pending_px[$];
        int              errors;

        function new();
            layer_cnt = 3'd1;
            dir       = DIR_TO_SHARE;
            errors    = 0;
        endfunction

        function pixel_res_t convert_alphas(alpha_t a0, alpha_t a1, alpha_t a2);
            int         src[PIXEL_FIELDS];
            int         dst[PIXEL_FIELDS];
            int         used;
            int         vis;
            int         v;
            int         q;
            int         r;
            pixel_res_t res;
            src[0]  = a0;
            src[1]  = a1;
            src[2]  = a2;
            dst     = '{default: 0};
            res.sat = 1'b0;
            if (layer_cnt < 2) begin
                dst = src;
            end
            else begin
                used = int'(layer_cnt) - 1;
                if (used > ALPHA_LAYERS)
                    used = ALPHA_LAYERS;
                if (used > PIXEL_FIELDS)
                    used = PIXEL_FIELDS;
                vis = FULL_ALPHA;
                for (int k = used - 1; k >= 0; k--) begin
                    if (dir == DIR_TO_SHARE) begin
                        v = (src[k] * vis + 127) / 255;
                        if (v > vis)
                            v = vis;
                        vis -= v;
                        dst[k] = v;
                    end
                    else if (vis <= 0) begin
                        dst[k] = 0;
                    end
                    else begin
                        q = (src[k] * 255) / vis;
                        r = (src[k] * 255) % vis;
                        v = (r <= vis / 2) ? q : q + 1;
                        if (v > 255) begin
                            v       = 255;
                            res.sat = 1'b1;
                        end
                        dst[k] = v;
                        vis -= src[k];
                    end
                end
            end
            res.o0 = alpha_t'(dst[0]);
            res.o1 = alpha_t'(dst[1]);
            res.o2 = alpha_t'(dst[2]);
            return res;
        endfunction

        function void note_pixel(alpha_t a0, alpha_t a1, alpha_t a2);
            pending_px = {pending_px, convert_alphas(a0, a1, a2)};
        endfunction

        function void check_field(string name, alpha_t want, alpha_t got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(pixel_res_t got);
            pixel_res_t want;
            if (pending_px.size() == 0) begin
                $display("%0t: unexpected result: expected none, got %0d %0d %0d sat %0d",
                         $time, got.o0, got.o1, got.o2, got.sat);
                errors++;
                return;
            end
            want = pending_px.pop_front();
            check_field("out_0", want.o0, got.o0);
            check_field("out_1", want.o1, got.o1);
            check_field("out_2", want.o2, got.o2);
            check_field("saturated", alpha_t'(want.sat), alpha_t'(got.sat));
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    alpha_t                alpha_0   = '0;
    alpha_t                alpha_1   = '0;
    alpha_t                alpha_2   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    alpha_t                out_0;
    alpha_t                out_1;
    alpha_t                out_2;
    logic                  saturated;

    logic                  calm      = 1'b0;
    int                    cycles    = 0;
    alpha_scoreboard       sb        = new();

    layer_alpha_convert dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .alpha_0   (alpha_0),
        .alpha_1   (alpha_1),
        .alpha_2   (alpha_2),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_0     (out_0),
        .out_1     (out_1),
        .out_2     (out_2),
        .saturated (saturated)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_ready <= calm || ($urandom_range(0, 99) >= 8);
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_pixel(alpha_0, alpha_1, alpha_2);
            if (out_valid && out_ready)
                sb.check_pixel({out_0, out_1, out_2, saturated});
        end
    end

    task automatic send_pixel(input alpha_t a0, input alpha_t a1, input alpha_t a2);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 8) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        alpha_0  <= a0;
        alpha_1  <= a1;
        alpha_2  <= a2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // hold off until every predicted pixel has come back
    task automatic drain_pixels();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_px.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(input int lc, input dir_t d);
        drain_pixels();
        repeat (NSTAGE + 2) @(posedge clk);
        write_reg(REG_LAYER_COUNT, CFG_DATA_W'(lc));
        write_reg(REG_DIRECTION, CFG_DATA_W'(d));
        sb.layer_cnt = LC_W'(lc);
        sb.dir       = d;
    endtask

    function automatic alpha_t pick_alpha();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return alpha_t'($urandom_range(0, 3));
            3:       return alpha_t'($urandom_range(252, 255));
            default: return alpha_t'($urandom);
        endcase
    endfunction

    task automatic send_random_pixel();
        int room;
        alpha_t s0;
        alpha_t s1;
        alpha_t s2;
        if (sb.dir == DIR_TO_STACKED && $urandom_range(0, 9) < 6) begin
            // shares that fit within full visibility, often using all of it
            room = 255;
            s2   = alpha_t'($urandom_range(0, room));
            room -= s2;
            s1   = alpha_t'($urandom_range(0, room));
            room -= s1;
            s0   = ($urandom_range(0, 2) == 0) ? alpha_t'(room)
                                               : alpha_t'($urandom_range(0, room));
            send_pixel(s0, s1, s2);
        end
        else begin
            send_pixel(pick_alpha(), pick_alpha(), pick_alpha());
        end
    endtask

    task automatic run_directed();
        set_config(4, DIR_TO_SHARE);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd64, 8'd1);
        send_pixel(8'd1, 8'd127, 8'd254);
        send_pixel(8'd0, 8'd0, 8'd255);
        set_config(4, DIR_TO_STACKED);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd55, 8'd200);
        send_pixel(8'd10, 8'd200, 8'd200);
        send_pixel(8'd1, 8'd1, 8'd253);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd85, 8'd85, 8'd85);
        set_config(0, DIR_TO_STACKED);
        send_pixel(8'd17, 8'd200, 8'd255);
        set_config(1, DIR_TO_SHARE);
        send_pixel(8'd255, 8'd0, 8'd128);
        set_config(2, DIR_TO_STACKED);
        send_pixel(8'd200, 8'd9, 8'd9);
        send_pixel(8'd255, 8'd0, 8'd0);
        set_config(3, DIR_TO_SHARE);
        send_pixel(8'd255, 8'd255, 8'd3);
        set_config(7, DIR_TO_STACKED);
        send_pixel(8'd40, 8'd100, 8'd120);
        set_config(5, DIR_TO_SHARE);
        send_pixel(8'd77, 8'd88, 8'd99);
    endtask

    initial
    begin
        int n_items;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        for (int p = 0; p < 16; p++) begin
            set_config((p / 2) % 8, (p % 2) ? DIR_TO_STACKED : DIR_TO_SHARE);
            calm    = (p == 6 || p == 11);
            n_items = $urandom_range(45, 65);
            for (int i = 0; i < n_items; i++) begin
                if (p == 3 && i == 20)
                    drain_pixels();
                send_random_pixel();
            end
        end
        calm = 1'b0;

        drain_pixels();
        repeat (NSTAGE + 4) @(posedge clk);
        if (sb.errors == 0 && sb.pending_px.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
